>>> hdl/nrq_pkg.sv
// ----------------------------------------------------------------------------
// nrq_pkg
// Shared types and constants of the notification retransmit queue.
// ----------------------------------------------------------------------------
package nrq_pkg;

  // default queue size
  localparam int DEF_QUEUE_DEPTH = 8;

  // field widths
  localparam int SEQ_W   = 32;
  localparam int SVC_W   = 16;
  localparam int TIME_W  = 32;
  localparam int RETRY_W = 4;
  localparam int HINT_W  = 3;
  localparam int KIND_W  = 2;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // commands
  localparam logic [CMD_W-1:0] CMD_SUBMIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESPONSE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REATTACH = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SUBMIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEND     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 2'd3;

  // hints
  localparam logic [HINT_W-1:0] HINT_OK        = 3'd0;
  localparam logic [HINT_W-1:0] HINT_FULL      = 3'd1;
  localparam logic [HINT_W-1:0] HINT_REATTACH  = 3'd2;
  localparam logic [HINT_W-1:0] HINT_FAILED    = 3'd3;
  localparam logic [HINT_W-1:0] HINT_NO_CRYPTO = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRYPTO     = 3'd4;

  // register reset values
  localparam logic [15:0]        RST_MIN_GAP    = 16'd100;
  localparam logic [31:0]        RST_QUOTA      = 32'd60000;
  localparam logic [RETRY_W-1:0] RST_RETRY_LIM  = 4'd8;
  localparam logic [15:0]        RST_RETRY_BASE = 16'd1000;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [SVC_W-1:0]  svc;
    logic [HINT_W-1:0] hint;
  } res_t;

  // shared time unit request
  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              lt;
    logic              eq;
  } alu_rsp_t;

endpackage

>>> hdl/nrq_alu.sv
// ----------------------------------------------------------------------------
// nrq_alu
// Shared 32-bit add/subtract and compare unit used by the sequencer steps.
// ----------------------------------------------------------------------------
module nrq_alu (
  input  nrq_pkg::alu_req_t req,
  output nrq_pkg::alu_rsp_t rsp
);
  import nrq_pkg::*;

  logic [TIME_W-1:0] b_op;

  // one adder, b inverted for subtract; wrapped "earlier than" is the sign bit
  assign b_op    = req.sub ? ~req.b : req.b;
  assign rsp.res = req.a + b_op + {{(TIME_W-1){1'b0}}, req.sub};
  assign rsp.lt  = rsp.res[TIME_W-1];
  assign rsp.eq  = (req.a == req.b);

endmodule

>>> hdl/nrq_out_reg.sv
// ----------------------------------------------------------------------------
// nrq_out_reg
// Output register of the result stream.
// ----------------------------------------------------------------------------
module nrq_out_reg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  nrq_pkg::res_t                      res,
  output logic                               free,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [nrq_pkg::OUT_DATA_W-1:0]     m_tdata,  // out_seq, out_pns_id, hint
  output logic [nrq_pkg::KIND_W-1:0]         m_tuser   // kind
);
  import nrq_pkg::*;

  res_t hold;

  assign free     = !m_tvalid || m_tready;
  assign m_tuser  = hold.kind;
  assign m_tdata  = {5'd0, hold.hint, hold.svc, hold.seq};

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= res;
    end
  end

endmodule

>>> hdl/notification_retransmit_queue.sv
// ----------------------------------------------------------------------------
// notification_retransmit_queue
// Queue of pending notifications with retry scheduling, driven by a small
// sequencer around one shared add/compare unit.
// ----------------------------------------------------------------------------
// results: none for a reattach or for a tick with no entry due; a full submit
//   goes straight to the output register, other items after their scans
// throughput: one item at a time, set by the single add/compare unit that
//   visits one entry per cycle during match, backoff and earliest-due scans
// reset: queue empty, counters and clocks zero, registers at defaults
// ----------------------------------------------------------------------------
module notification_retransmit_queue #(
  parameter int QUEUE_DEPTH = nrq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pns_id, resp_seq, ack_flag, fail_flag, quota_flag, reattach_flag
  input  logic [nrq_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [nrq_pkg::CMD_W-1:0]          s_tuser,  // cmd
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [nrq_pkg::OUT_DATA_W-1:0]     m_tdata,  // out_seq, out_pns_id, hint
  output logic [nrq_pkg::KIND_W-1:0]         m_tuser,  // kind
  input  logic                               cfg_we,
  input  logic [nrq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nrq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import nrq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUB   = 4'd1;
  localparam logic [3:0] S_TICK  = 4'd2;
  localparam logic [3:0] S_SEND  = 4'd3;
  localparam logic [3:0] S_MATCH = 4'd4;
  localparam logic [3:0] S_QUOTA = 4'd5;
  localparam logic [3:0] S_DROP  = 4'd6;
  localparam logic [3:0] S_SEL0  = 4'd7;
  localparam logic [3:0] S_SEL   = 4'd8;
  localparam logic [3:0] S_FIX   = 4'd9;
  localparam logic [3:0] S_GAP   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  // entry storage
  logic [SEQ_W-1:0]   e_seq   [QUEUE_DEPTH];
  logic [SVC_W-1:0]   e_svc   [QUEUE_DEPTH];
  logic [RETRY_W-1:0] e_ret   [QUEUE_DEPTH];
  logic [TIME_W-1:0]  e_due   [QUEUE_DEPTH];
  logic [HINT_W-1:0]  e_hint  [QUEUE_DEPTH];

  // control state
  logic [3:0]        state;
  logic [CW-1:0]     fill;
  logic [SEQ_W-1:0]  next_seq;
  logic              reattach;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] last_send;
  logic [TIME_W-1:0] backoff;
  logic [IW-1:0]     sel_slot;
  logic [CW-1:0]     idx;
  logic [IW-1:0]     best;
  logic [TIME_W-1:0] best_due;
  logic [IW-1:0]     drop_pos;
  logic [1:0]        passes;
  res_t              res;

  // latched item
  logic [CMD_W-1:0]  cmd;
  logic [SVC_W-1:0]  pns;
  logic [SEQ_W-1:0]  rseq;
  logic              ack_f, fail_f, quota_f, reatt_f;

  // configuration
  logic [15:0]        min_gap;
  logic [31:0]        quota_ms;
  logic [RETRY_W-1:0] retry_lim;
  logic [15:0]        retry_base;
  logic               crypto;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     out_free;
  logic     out_load;

  logic [IW-1:0]      ii;
  logic [IW-1:0]      last_i;
  logic [CW-1:0]      last_c;
  logic [RETRY_W-1:0] ret_new;
  logic [TIME_W-1:0]  delay;
  logic               do_complete;
  logic [HINT_W-1:0]  tick_hint;

  assign ii       = idx[IW-1:0];
  assign last_c   = fill - CW'(1);
  assign last_i   = last_c[IW-1:0];
  assign ret_new  = e_ret[sel_slot] + RETRY_W'(1);
  assign delay    = {16'd0, retry_base} << ret_new;
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_EMIT) && out_free;

  assign do_complete = (e_ret[sel_slot] >= retry_lim) || (e_hint[sel_slot] != HINT_OK) ||
                       !crypto;
  assign tick_hint   = (e_ret[sel_slot] >= retry_lim) ? HINT_FAILED :
                       ((e_hint[sel_slot] != HINT_OK) ? e_hint[sel_slot] : HINT_NO_CRYPTO);

  // operand select for the shared unit
  always_comb begin
    alu_req = '{sub: 1'b1, a: now_ms, b: backoff};
    unique case (state)
      S_TICK:  alu_req = '{sub: 1'b1, a: e_due[sel_slot], b: now_ms};
      S_SEND:  alu_req = '{sub: 1'b0, a: now_ms, b: delay};
      S_MATCH: alu_req = '{sub: 1'b1, a: e_seq[ii], b: rseq};
      S_QUOTA: begin
        if (idx >= fill) alu_req = '{sub: 1'b0, a: now_ms, b: quota_ms};
        else             alu_req = '{sub: 1'b0, a: e_due[ii], b: quota_ms};
      end
      S_SEL:   alu_req = '{sub: 1'b1, a: e_due[ii], b: best_due};
      S_FIX:   alu_req = '{sub: 1'b1, a: e_due[best], b: last_send};
      S_GAP:   alu_req = '{sub: 1'b0, a: e_due[best], b: {16'd0, min_gap}};
      default: alu_req = '{sub: 1'b1, a: now_ms, b: backoff};
    endcase
  end

  nrq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap    <= RST_MIN_GAP;
      quota_ms   <= RST_QUOTA;
      retry_lim  <= RST_RETRY_LIM;
      retry_base <= RST_RETRY_BASE;
      crypto     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_GAP:    min_gap    <= cfg_data[15:0];
        REG_QUOTA:      quota_ms   <= cfg_data;
        REG_RETRY_LIM:  retry_lim  <= cfg_data[RETRY_W-1:0];
        REG_RETRY_BASE: retry_base <= cfg_data[15:0];
        REG_CRYPTO:     crypto     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer and queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      next_seq  <= '0;
      reattach  <= 1'b0;
      now_ms    <= '0;
      last_send <= '0;
      backoff   <= '0;
      sel_slot  <= '0;
      idx       <= '0;
      passes    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            unique case (s_tuser)
              CMD_SUBMIT: begin
                if (fill >= DEPTH_C) begin
                  next_seq <= next_seq + SEQ_W'(1);
                  state    <= S_EMIT;
                end else begin
                  state <= S_SUB;
                end
              end
              CMD_TICK: begin
                now_ms <= now_ms + TIME_W'(1);
                state  <= S_TICK;
              end
              CMD_RESPONSE: begin
                idx   <= '0;
                state <= S_MATCH;
              end
              CMD_REATTACH: reattach <= 1'b0;
              default: ;
            endcase
          end
        end
        S_SUB: begin
          fill     <= fill + CW'(1);
          next_seq <= next_seq + SEQ_W'(1);
          passes   <= 2'd1;
          state    <= S_SEL0;
        end
        S_TICK: begin
          if (fill == '0 || CW'(sel_slot) >= fill || !alu_rsp.lt) begin
            state <= S_IDLE;
          end else if (do_complete) begin
            drop_pos <= sel_slot;
            passes   <= 2'd2;
            state    <= S_DROP;
          end else begin
            last_send <= now_ms;
            state     <= S_SEND;
          end
        end
        S_SEND: begin
          passes <= 2'd2;
          state  <= S_SEL0;
        end
        S_MATCH: begin
          if (idx >= fill) begin
            state <= S_EMIT;
          end else if (alu_rsp.eq) begin
            drop_pos <= ii;
            passes   <= 2'd1;
            if (reatt_f) reattach <= 1'b1;
            if (quota_f) begin
              idx   <= '0;
              state <= S_QUOTA;
            end else begin
              state <= S_DROP;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_QUOTA: begin
          if (idx >= fill) begin
            backoff <= alu_rsp.res;
            state   <= S_DROP;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_DROP: begin
          fill  <= last_c;
          state <= S_SEL0;
        end
        S_SEL0: begin
          if (passes == 2'd0 || fill == '0) begin
            passes <= 2'd0;
            state  <= S_EMIT;
          end else begin
            idx   <= CW'(1);
            state <= S_SEL;
          end
        end
        S_SEL: begin
          if (idx >= fill) begin
            sel_slot <= best;
            state    <= S_FIX;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_FIX: begin
          if (alu_rsp.lt) begin
            state <= S_GAP;
          end else begin
            passes <= passes - 2'd1;
            state  <= S_SEL0;
          end
        end
        S_GAP: begin
          passes <= passes - 2'd1;
          state  <= S_SEL0;
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath: latched item, pending result, entries, scan bests
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd     <= s_tuser;
        pns     <= s_tdata[15:0];
        rseq    <= s_tdata[47:16];
        ack_f   <= s_tdata[48];
        fail_f  <= s_tdata[49];
        quota_f <= s_tdata[50];
        reatt_f <= s_tdata[51];
        res     <= '{kind: KIND_SUBMIT, seq: next_seq, svc: '0, hint: HINT_FULL};
      end
      S_SUB: begin
        e_seq[fill[IW-1:0]]  <= next_seq;
        e_svc[fill[IW-1:0]]  <= pns;
        e_ret[fill[IW-1:0]]  <= '0;
        e_hint[fill[IW-1:0]] <= reattach ? HINT_REATTACH : HINT_OK;
        e_due[fill[IW-1:0]]  <= alu_rsp.lt ? backoff : now_ms;
        res <= '{kind: KIND_SUBMIT, seq: next_seq, svc: '0,
                 hint: reattach ? HINT_REATTACH : HINT_OK};
      end
      S_TICK: begin
        if (do_complete) begin
          res <= '{kind: KIND_COMPLETE, seq: e_seq[sel_slot], svc: '0, hint: tick_hint};
        end else begin
          res <= '{kind: KIND_SEND, seq: e_seq[sel_slot], svc: e_svc[sel_slot],
                   hint: HINT_OK};
        end
      end
      S_SEND: begin
        e_ret[sel_slot] <= ret_new;
        e_due[sel_slot] <= alu_rsp.res;
      end
      S_MATCH: begin
        if (idx >= fill) begin
          res <= '{kind: KIND_UNKNOWN, seq: rseq, svc: '0, hint: HINT_OK};
        end else begin
          res <= '{kind: KIND_COMPLETE, seq: rseq, svc: '0,
                   hint: (fail_f || !ack_f) ? HINT_FAILED : HINT_OK};
        end
      end
      S_QUOTA: begin
        if (idx < fill) e_due[ii] <= alu_rsp.res;
      end
      S_DROP: begin
        e_seq[drop_pos]  <= e_seq[last_i];
        e_svc[drop_pos]  <= e_svc[last_i];
        e_ret[drop_pos]  <= e_ret[last_i];
        e_due[drop_pos]  <= e_due[last_i];
        e_hint[drop_pos] <= e_hint[last_i];
      end
      S_SEL0: begin
        best     <= '0;
        best_due <= e_due[0];
      end
      S_SEL: begin
        if (idx < fill && alu_rsp.lt) begin
          best     <= ii;
          best_due <= e_due[ii];
        end
      end
      S_GAP: e_due[best] <= alu_rsp.res;
      default: ;
    endcase
  end

  nrq_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_C) else $error("queue fill beyond depth");

  a_sel_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && fill != '0) |-> (CW'(sel_slot) < fill))
    else $error("selected slot outside the queue while idle");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (next_seq != $past(next_seq)) |-> (next_seq == $past(next_seq) + SEQ_W'(1)))
    else $error("sequence number skipped");

  a_cmd_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_MATCH) |-> (cmd == CMD_RESPONSE))
    else $error("match scan without a response item");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the notification retransmit queue. Items are sent on the
// stream input with random gaps; a built-in model of the queue predicts each
// result, and every result item is compared field by field with the oldest
// prediction. Register settings change between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nrq_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int LIMIT = 600000;
  localparam int SETTLE = 80;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [15:0]      pns;
    logic [31:0]      rseq;
    logic [3:0]       flags;  // ack, fail, quota, reattach
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  notification_retransmit_queue dut (.*);

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  cmd_item_t pending_cmds[$];
  res_t      expected_results[$];
  int        offered = 0;
  int        accepted = 0;
  int        errors = 0;
  int        cycles = 0;

  // queue model state
  logic [31:0] q_seq[DEPTH];
  logic [15:0] q_svc[DEPTH];
  logic [3:0]  q_retries[DEPTH];
  logic [31:0] q_due[DEPTH];
  logic [2:0]  q_hint[DEPTH];
  int          q_fill;
  logic [31:0] seq_counter;
  logic        need_reattach;
  logic [31:0] clock_ms, last_sent_ms, hold_until;
  int          chosen;
  logic [15:0] gap_ms;
  logic [31:0] quota_ms;
  logic [3:0]  max_retries;
  logic [15:0] base_ms;
  logic        crypto_on;

  function automatic bit earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  // pick the earliest due entry and add the gap to its due time if before the last send
  function automatic void pick_earliest();
    int n;
    n = 0;
    if (q_fill == 0) return;
    for (int i = 1; i < q_fill; i++)
      if (earlier(q_due[i], q_due[n])) n = i;
    chosen = n;
    if (earlier(q_due[n], last_sent_ms)) q_due[n] = q_due[n] + gap_ms;
  endfunction

  // the last entry fills the freed slot
  function automatic void remove_entry(int s);
    int last;
    last = q_fill - 1;
    q_seq[s] = q_seq[last];
    q_svc[s] = q_svc[last];
    q_retries[s] = q_retries[last];
    q_due[s] = q_due[last];
    q_hint[s] = q_hint[last];
    q_fill = last;
    pick_earliest();
  endfunction

  function automatic bit queue_step(cmd_item_t it, output res_t r);
    logic [31:0] sq;
    logic [2:0]  h;
    int          s;
    r = '0;
    case (it.cmd)
      CMD_SUBMIT: begin
        sq = seq_counter;
        seq_counter = seq_counter + 32'd1;
        r.kind = KIND_SUBMIT;
        r.seq = sq;
        if (q_fill >= DEPTH) begin
          r.hint = HINT_FULL;
          return 1;
        end
        h = need_reattach ? HINT_REATTACH : HINT_OK;
        q_seq[q_fill] = sq;
        q_svc[q_fill] = it.pns;
        q_retries[q_fill] = '0;
        q_hint[q_fill] = h;
        q_due[q_fill] = earlier(clock_ms, hold_until) ? hold_until : clock_ms;
        q_fill++;
        pick_earliest();
        r.hint = h;
        return 1;
      end
      CMD_TICK: begin
        clock_ms = clock_ms + 32'd1;
        if (q_fill == 0 || chosen >= q_fill) return 0;
        s = chosen;
        if (!earlier(q_due[s], clock_ms)) return 0;
        r.seq = q_seq[s];
        if (q_retries[s] >= max_retries || q_hint[s] != HINT_OK || !crypto_on) begin
          r.kind = KIND_COMPLETE;
          r.hint = (q_retries[s] >= max_retries) ? HINT_FAILED
                 : (q_hint[s] != HINT_OK ? q_hint[s] : HINT_NO_CRYPTO);
          remove_entry(s);
          pick_earliest();
          return 1;
        end
        last_sent_ms = clock_ms;
        q_retries[s] = q_retries[s] + 4'd1;
        q_due[s] = clock_ms + ({16'd0, base_ms} << q_retries[s]);
        r.kind = KIND_SEND;
        r.svc = q_svc[s];
        r.hint = HINT_OK;
        pick_earliest();
        pick_earliest();
        return 1;
      end
      CMD_RESPONSE: begin
        r.seq = it.rseq;
        s = -1;
        for (int i = 0; i < q_fill; i++)
          if (s < 0 && q_seq[i] == it.rseq) s = i;
        if (s < 0) begin
          r.kind = KIND_UNKNOWN;
          return 1;
        end
        r.kind = KIND_COMPLETE;
        r.hint = it.flags[1] ? HINT_FAILED : (it.flags[0] ? HINT_OK : HINT_FAILED);
        if (it.flags[2]) begin
          for (int k = 0; k < q_fill; k++) q_due[k] = q_due[k] + quota_ms;
          hold_until = clock_ms + quota_ms;
        end
        if (it.flags[3]) need_reattach = 1'b1;
        remove_entry(s);
        return 1;
      end
      default: begin
        need_reattach = 1'b0;
        return 0;
      end
    endcase
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    cmd_item_t it;
    if (!rst && offered == accepted) begin
      if (pending_cmds.size() == 0 ||
          (!(cycles > 6000 && cycles < 9000) && $urandom_range(0, 99) < 14)) begin
        s_tvalid <= 1'b0;
      end else begin
        it = pending_cmds.pop_front();
        s_tdata <= {4'd0, it.flags[3], it.flags[2], it.flags[1], it.flags[0],
                    it.rseq, it.pns};
        s_tuser <= it.cmd;
        s_tvalid <= 1'b1;
        offered <= offered + 1;
      end
    end
  end

  // result receiver, with one long hold-off to fill the block
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (cycles > 3000 && cycles < 3400) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (cycles > 6000 && cycles < 9000) || $urandom_range(0, 99) >= 14;
    end
  end

  // monitor: predict accepted items, check result items
  always @(posedge clk) begin
    cmd_item_t it;
    res_t      r, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation: kind %0d seq %0d", m_tuser, m_tdata[31:0]);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tuser !== exp_r.kind) begin
          $error("kind: expected %0d, actual %0d", exp_r.kind, m_tuser);
          errors++;
        end
        if (m_tdata[31:0] !== exp_r.seq) begin
          $error("out_seq: expected %0d, actual %0d", exp_r.seq, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[47:32] !== exp_r.svc) begin
          $error("out_pns_id: expected %0d, actual %0d", exp_r.svc, m_tdata[47:32]);
          errors++;
        end
        if (m_tdata[50:48] !== exp_r.hint) begin
          $error("hint: expected %0d, actual %0d", exp_r.hint, m_tdata[50:48]);
          errors++;
        end
        if (m_tdata[55:51] !== 5'd0) begin
          $error("padding: expected 0, actual %0d", m_tdata[55:51]);
          errors++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      it.cmd = s_tuser;
      it.pns = s_tdata[15:0];
      it.rseq = s_tdata[47:16];
      it.flags = s_tdata[51:48];
      if (queue_step(it, r)) expected_results.push_back(r);
      accepted <= accepted + 1;
    end
  end

  task automatic send(logic [CMD_W-1:0] c, logic [15:0] p, logic [31:0] q, logic [3:0] f);
    cmd_item_t it;
    it.cmd = c;
    it.pns = p;
    it.rseq = q;
    it.flags = f;
    pending_cmds.push_back(it);
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && offered == accepted && expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MIN_GAP:    gap_ms = val[15:0];
      REG_QUOTA:      quota_ms = val;
      REG_RETRY_LIM:  max_retries = val[3:0];
      REG_RETRY_BASE: base_ms = val[15:0];
      default:        crypto_on = val[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] g, logic [31:0] qb, logic [3:0] lim,
                         logic [15:0] b, logic cr);
    write_reg(REG_MIN_GAP, {16'd0, g});
    write_reg(REG_QUOTA, qb);
    write_reg(REG_RETRY_LIM, {28'd0, lim});
    write_reg(REG_RETRY_BASE, {16'd0, b});
    write_reg(REG_CRYPTO, {31'd0, cr});
  endtask

  // random phase: mostly submits, ticks and responses to live sequences
  task automatic random_phase(int n);
    int          pick;
    logic [31:0] q;
    for (int i = 0; i < n; i++) begin
      wait (pending_cmds.size() < 4);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send(CMD_SUBMIT, 16'($urandom), $urandom, 4'($urandom));
      end else if (pick < 72) begin
        send(CMD_TICK, 16'($urandom), $urandom, 4'($urandom));
      end else if (pick < 95) begin
        q = ($urandom_range(0, 9) == 0) ? $urandom
          : seq_counter - $urandom_range(1, 10);
        send(CMD_RESPONSE, 16'($urandom), q,
             {$urandom_range(0, 7) == 0, $urandom_range(0, 4) == 0,
              $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0});
      end else begin
        send(CMD_REATTACH, 16'($urandom), $urandom, 4'($urandom));
      end
    end
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      q_seq[i] = '0; q_svc[i] = '0; q_retries[i] = '0; q_due[i] = '0; q_hint[i] = '0;
    end
    q_fill = 0; seq_counter = '0; need_reattach = 1'b0; clock_ms = '0;
    last_sent_ms = '0; hold_until = '0; chosen = 0;
    gap_ms = RST_MIN_GAP; quota_ms = RST_QUOTA; max_retries = RST_RETRY_LIM;
    base_ms = RST_RETRY_BASE; crypto_on = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: fill to overflow, serve, every response kind, reattach
    send(CMD_SUBMIT, 16'h0000, '0, 4'h0);
    send(CMD_SUBMIT, 16'hFFFF, '1, 4'hF);
    for (int i = 0; i < 7; i++) send(CMD_SUBMIT, 16'(16'h1000 + i), '0, 4'h0);
    send(CMD_TICK, '0, '0, 4'h0);
    send(CMD_TICK, '0, '0, 4'h0);
    send(CMD_RESPONSE, '0, 32'd0, 4'b0001);
    send(CMD_RESPONSE, '0, 32'd1, 4'b0011);
    send(CMD_RESPONSE, '0, 32'd2, 4'b0000);
    send(CMD_RESPONSE, '0, 32'd3, 4'b0101);
    send(CMD_RESPONSE, '0, 32'd4, 4'b1001);
    send(CMD_SUBMIT, 16'h5A5A, '0, 4'h0);
    send(CMD_RESPONSE, '0, 32'hFFFFFFFF, 4'b1111);
    send(CMD_TICK, '0, '0, 4'h0);
    send(CMD_REATTACH, '0, '0, 4'h0);
    send(CMD_SUBMIT, 16'hA5A5, '0, 4'h0);
    send(CMD_TICK, '0, '0, 4'h0);
    drain();

    random_phase(180);
    drain();
    set_all(16'd0, 32'd0, 4'd1, 16'd1, 1'b1);
    random_phase(190);
    drain();
    set_all(16'hFFFF, 32'hFFFFFFFF, 4'd15, 16'hFFFF, 1'b0);
    random_phase(180);
    drain();
    set_all(16'd3, 32'd5, 4'd3, 16'd2, 1'b1);
    random_phase(190);
    drain();
    set_all(16'd50, 32'd100, 4'd15, 16'd1, 1'b1);
    random_phase(190);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
